/* src/swvf_pkg.sv */
// ----------------------------------------------------------------------------
// swvf_pkg
// Types and constants shared by the single-wire volume frame generator.
// ----------------------------------------------------------------------------
package swvf_pkg;

  localparam int TimeW = 12;
  localparam int AddrW = 8;
  localparam int VolW  = 5;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHIP_ADDRESS   = 3'd0,
    REG_START_TIME     = 3'd1,
    REG_STOP_TIME      = 3'd2,
    REG_ZERO_LOW_TIME  = 3'd3,
    REG_ZERO_HIGH_TIME = 3'd4,
    REG_ONE_LOW_TIME   = 3'd5,
    REG_ONE_HIGH_TIME  = 3'd6
  } cfg_reg_e;

  localparam logic [AddrW-1:0] ChipAddressRst  = 8'd0;
  localparam logic [TimeW-1:0] StartTimeRst    = 12'd100;
  localparam logic [TimeW-1:0] StopTimeRst     = 12'd100;
  localparam logic [TimeW-1:0] ZeroLowTimeRst  = 12'd60;
  localparam logic [TimeW-1:0] ZeroHighTimeRst = 12'd20;
  localparam logic [TimeW-1:0] OneLowTimeRst   = 12'd20;
  localparam logic [TimeW-1:0] OneHighTimeRst  = 12'd60;

  typedef struct packed {
    logic [AddrW-1:0] chip_address;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] stop_time;
    logic [TimeW-1:0] zero_low_time;
    logic [TimeW-1:0] zero_high_time;
    logic [TimeW-1:0] one_low_time;
    logic [TimeW-1:0] one_high_time;
  } cfg_t;

  typedef struct packed {
    logic             level;
    logic [TimeW-1:0] dur;
    logic             last;
  } seg_t;

endpackage

/* src/single_wire_volume_frame_gen.sv */
// ----------------------------------------------------------------------------
// single_wire_volume_frame_gen
// Emits the single-wire volume frame for each request as level/duration items.
// ----------------------------------------------------------------------------
// Each request yields 2*ADDRESS_BITS + 2*DATA_BITS + 11 segment items (37 at
// the default sizes), one per cycle when the output side is ready; the frame
// is walked by a segment counter that decodes one segment per cycle into the
// output register. A one-deep input buffer takes the next request while the
// current frame is still going out, so frames follow each other without a gap.
module single_wire_volume_frame_gen #(
  parameter int ADDRESS_BITS = 8,
  parameter int DATA_BITS    = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swvf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [swvf_pkg::TimeW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [swvf_pkg::VolW-1:0]    volume_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         pin_level_o,
  output logic [swvf_pkg::TimeW-1:0]   duration_us_o,
  output logic                         last_segment_o
);
  import swvf_pkg::*;

  localparam int NSeg = 2 * ADDRESS_BITS + 2 * DATA_BITS + 11;
  localparam int IdxW = $clog2(NSeg);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NSeg - 1);

  cfg_t cfg;
  seg_t seg;

  logic            buf_valid_q;
  logic [VolW-1:0] buf_vol_q;
  logic            act_q;
  logic [IdxW-1:0] idx_q;
  logic [VolW-1:0] vol_q;
  logic            out_valid_q;
  seg_t            out_q;

  logic in_acc, adv, fin, load;

  swvf_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  swvf_seg_decode #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .DATA_BITS    (DATA_BITS),
    .IdxW         (IdxW)
  ) u_dec (
    .idx_i (idx_q),
    .vol_i (vol_q),
    .cfg_i (cfg),
    .seg_o (seg)
  );

  assign in_ready_o = !buf_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign adv        = act_q && (!out_valid_q || out_ready_i);
  assign fin        = adv && (idx_q == LastIdx);
  assign load       = buf_valid_q && (!act_q || fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_acc) begin
      buf_valid_q <= 1'b1;
    end else if (load) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_vol_q <= volume_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= '0;
    end else if (load) begin
      act_q <= 1'b1;
      idx_q <= '0;
    end else if (fin) begin
      act_q <= 1'b0;
    end else if (adv) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vol_q <= buf_vol_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= seg;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pin_level_o    = out_q.level;
  assign duration_us_o  = out_q.dur;
  assign last_segment_o = out_q.last;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> idx_q <= LastIdx)
    else $error("segment index past end of frame");

  a_last_at_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_q.last == $past(fin))
    else $error("last flag not on final segment");

  a_idle_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q && !act_q |=> act_q && !buf_valid_q)
    else $error("buffered item not started");

  a_buf_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> buf_valid_q)
    else $error("accepted item lost");

endmodule

/* src/swvf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// swvf_cfg_regs
// Timing and address registers, written through a plain write port.
// ----------------------------------------------------------------------------
module swvf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swvf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [swvf_pkg::TimeW-1:0]   cfg_data_i,
  output swvf_pkg::cfg_t               cfg_o
);
  import swvf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CHIP_ADDRESS:   cfg_d.chip_address   = cfg_data_i[AddrW-1:0];
        REG_START_TIME:     cfg_d.start_time     = cfg_data_i;
        REG_STOP_TIME:      cfg_d.stop_time      = cfg_data_i;
        REG_ZERO_LOW_TIME:  cfg_d.zero_low_time  = cfg_data_i;
        REG_ZERO_HIGH_TIME: cfg_d.zero_high_time = cfg_data_i;
        REG_ONE_LOW_TIME:   cfg_d.one_low_time   = cfg_data_i;
        REG_ONE_HIGH_TIME:  cfg_d.one_high_time  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chip_address   <= ChipAddressRst;
      cfg_q.start_time     <= StartTimeRst;
      cfg_q.stop_time      <= StopTimeRst;
      cfg_q.zero_low_time  <= ZeroLowTimeRst;
      cfg_q.zero_high_time <= ZeroHighTimeRst;
      cfg_q.one_low_time   <= OneLowTimeRst;
      cfg_q.one_high_time  <= OneHighTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/swvf_seg_decode.sv */
// ----------------------------------------------------------------------------
// swvf_seg_decode
// Maps a segment index of the frame to its line level and duration.
// ----------------------------------------------------------------------------
module swvf_seg_decode #(
  parameter int ADDRESS_BITS = 8,
  parameter int DATA_BITS    = 5,
  parameter int IdxW         = 6
) (
  input  logic [IdxW-1:0]          idx_i,
  input  logic [swvf_pkg::VolW-1:0] vol_i,
  input  swvf_pkg::cfg_t           cfg_i,
  output swvf_pkg::seg_t           seg_o
);
  import swvf_pkg::*;

  localparam int AStop  = 2 * ADDRESS_BITS + 1;
  localparam int DStart = AStop + 1;
  localparam int ZBase  = DStart + 1;
  localparam int VBase  = ZBase + 6;
  localparam int DStop  = VBase + 2 * DATA_BITS;

  localparam logic [IdxW-1:0] AStopI  = IdxW'(AStop);
  localparam logic [IdxW-1:0] DStartI = IdxW'(DStart);
  localparam logic [IdxW-1:0] ZBaseI  = IdxW'(ZBase);
  localparam logic [IdxW-1:0] VBaseI  = IdxW'(VBase);
  localparam logic [IdxW-1:0] DStopI  = IdxW'(DStop);

  logic [IdxW-1:0] rel;
  logic [2:0]      bit_pos;
  logic [7:0]      vol_ext;
  logic            is_bit;
  logic            bit_val;

  always_comb begin
    vol_ext = 8'(vol_i);
    rel     = '0;
    is_bit  = 1'b0;
    bit_val = 1'b0;
    seg_o   = '{level: 1'b1, dur: '0, last: 1'b0};
    if (idx_i == '0 || idx_i == DStartI) begin
      seg_o.dur = cfg_i.start_time;
    end else if (idx_i < AStopI) begin
      rel    = idx_i - IdxW'(1);
      is_bit = 1'b1;
    end else if (idx_i == AStopI || idx_i == DStopI) begin
      seg_o.level = 1'b0;
      seg_o.dur   = cfg_i.stop_time;
    end else if (idx_i < VBaseI) begin
      rel    = idx_i - ZBaseI;
      is_bit = 1'b1;
    end else if (idx_i < DStopI) begin
      rel    = idx_i - VBaseI;
      is_bit = 1'b1;
    end else begin
      seg_o.last = 1'b1;
    end
    bit_pos = 3'(rel >> 1);
    if (idx_i < AStopI) begin
      bit_val = cfg_i.chip_address[bit_pos];
    end else if (idx_i >= VBaseI) begin
      bit_val = vol_ext[bit_pos];
    end
    if (is_bit) begin
      seg_o.level = rel[0];
      case ({bit_val, rel[0]})
        2'b00:   seg_o.dur = cfg_i.zero_low_time;
        2'b01:   seg_o.dur = cfg_i.zero_high_time;
        2'b10:   seg_o.dur = cfg_i.one_low_time;
        default: seg_o.dur = cfg_i.one_high_time;
      endcase
    end
  end

endmodule

/* sim/single_wire_volume_frame_gen_test.sv */
// ----------------------------------------------------------------------------
// single_wire_volume_frame_gen_test
// Self-checking bench for the single-wire volume frame generator. Every
// accepted volume is expanded into its expected segment list from a local
// copy of the timing and address registers; each segment leaving the block is
// checked in order. Runs the reset settings, zero and full-scale timings, a mixed
// setting and a series of random settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module single_wire_volume_frame_gen_test;
  import swvf_pkg::*;

  localparam int AddrBits   = 8;
  localparam int DataBits   = 5;
  localparam int TailCycles = 64;
  localparam int CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  class frame_predictor;
    cfg_t regs;
    seg_t pending_segs[$];
    int   errors;

    function new();
      regs.chip_address   = ChipAddressRst;
      regs.start_time     = StartTimeRst;
      regs.stop_time      = StopTimeRst;
      regs.zero_low_time  = ZeroLowTimeRst;
      regs.zero_high_time = ZeroHighTimeRst;
      regs.one_low_time   = OneLowTimeRst;
      regs.one_high_time  = OneHighTimeRst;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
      case (idx)
        REG_CHIP_ADDRESS:   regs.chip_address   = data[AddrW-1:0];
        REG_START_TIME:     regs.start_time     = data;
        REG_STOP_TIME:      regs.stop_time      = data;
        REG_ZERO_LOW_TIME:  regs.zero_low_time  = data;
        REG_ZERO_HIGH_TIME: regs.zero_high_time = data;
        REG_ONE_LOW_TIME:   regs.one_low_time   = data;
        REG_ONE_HIGH_TIME:  regs.one_high_time  = data;
        default: ;
      endcase
    endfunction

    function void put_seg(input logic level, input logic [TimeW-1:0] dur, input logic last);
      seg_t s;
      s.level = level;
      s.dur   = dur;
      s.last  = last;
      pending_segs.push_back(s);
    endfunction

    function void put_bit(input logic one);
      if (one) begin
        put_seg(1'b0, regs.one_low_time, 1'b0);
        put_seg(1'b1, regs.one_high_time, 1'b0);
      end else begin
        put_seg(1'b0, regs.zero_low_time, 1'b0);
        put_seg(1'b1, regs.zero_high_time, 1'b0);
      end
    endfunction

    function void note_volume(input logic [VolW-1:0] vol);
      put_seg(1'b1, regs.start_time, 1'b0);
      for (int i = 0; i < AddrBits; i++) put_bit(regs.chip_address[i]);
      put_seg(1'b0, regs.stop_time, 1'b0);
      put_seg(1'b1, regs.start_time, 1'b0);
      for (int i = 0; i < 3; i++) put_bit(1'b0);
      for (int i = 0; i < DataBits; i++) put_bit(i < VolW ? vol[i] : 1'b0);
      put_seg(1'b0, regs.stop_time, 1'b0);
      put_seg(1'b1, '0, 1'b1);
    endfunction

    task check_segment(input logic level, input logic [TimeW-1:0] dur, input logic last);
      seg_t want;
      if (pending_segs.size() == 0) begin
        report($sformatf("segment %0b/%0d/%0b with no frame pending", level, dur, last));
        return;
      end
      want = pending_segs.pop_front();
      if (level !== want.level)
        report($sformatf("pin_level %0b, want %0b", level, want.level));
      if (dur !== want.dur)
        report($sformatf("duration_us %0d, want %0d", dur, want.dur));
      if (last !== want.last)
        report($sformatf("last_segment %0b, want %0b", last, want.last));
    endtask

    task finish_check();
      if (pending_segs.size() != 0)
        report($sformatf("%0d segments never came out", pending_segs.size()));
    endtask
  endclass

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx      = '0;
  logic [TimeW-1:0]   cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [VolW-1:0]    volume       = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic               pin_level;
  logic [TimeW-1:0]   duration_us;
  logic               last_segment;

  bit             quiet       = 1'b0;
  int             cycle_count = 0;
  frame_predictor board       = new();

  single_wire_volume_frame_gen #(
    .ADDRESS_BITS(AddrBits),
    .DATA_BITS   (DataBits)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .volume_i      (volume),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pin_level_o   (pin_level),
    .duration_us_o (duration_us),
    .last_segment_o(last_segment)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_segment(pin_level, duration_us, last_segment);
  end

  // hold ready for a random stretch, then maybe stall
  initial begin
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic apply_config(input logic [TimeW-1:0] addr_data, input logic [TimeW-1:0] st,
                              input logic [TimeW-1:0] sp, input logic [TimeW-1:0] zl,
                              input logic [TimeW-1:0] zh, input logic [TimeW-1:0] ol,
                              input logic [TimeW-1:0] oh);
    write_reg(REG_CHIP_ADDRESS, addr_data);
    write_reg(REG_START_TIME, st);
    write_reg(REG_STOP_TIME, sp);
    write_reg(REG_ZERO_LOW_TIME, zl);
    write_reg(REG_ZERO_HIGH_TIME, zh);
    write_reg(REG_ONE_LOW_TIME, ol);
    write_reg(REG_ONE_HIGH_TIME, oh);
    write_reg(RegUnused, TimeW'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_volume(input logic [VolW-1:0] vol);
    int gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    volume   <= vol;
    do @(posedge clk); while (!in_ready);
    board.note_volume(vol);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_segs.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return TimeW'($urandom);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_volume(5'd0);
    send_volume(5'd31);
    send_volume(5'd1);
    send_volume(5'd16);
    send_volume(5'd21);
    send_volume(5'd10);
    drain();

    // zero timings; high data bits on the address register must be dropped
    apply_config(12'hF00, '0, '0, '0, '0, '0, '0);
    send_volume(5'd31);
    send_volume(5'd0);
    drain();

    apply_config(12'hFFF, '1, '1, '1, '1, '1, '1);
    send_volume(5'd0);
    send_volume(5'd31);
    send_volume(5'd5);
    drain();

    apply_config(12'h0A5, 12'd1, 12'd4094, 12'h555, 12'hAAA, 12'd1, 12'd2048);
    send_volume(5'd10);
    send_volume(5'd21);
    send_volume(5'd31);
    send_volume(5'd0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4) quiet = 1'b1;
      apply_config(TimeW'($urandom), rand_time(), rand_time(), rand_time(), rand_time(),
                   rand_time(), rand_time());
      for (int n = 0; n < 20; n++) begin
        send_volume(VolW'($urandom_range(0, 31)));
        if (phase == 1 && n == 9) drain();
      end
      drain();
    end

    board.finish_check();
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
